@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: label");

// When the antecedent holds, the consequent holds on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`endif

@@ design/spa_pkg.sv @@
`default_nettype none

package spa_pkg;

    // Pool geometry and field widths
    localparam int SLOTS     = 8;
    localparam int REG_COUNT = 8;
    localparam int SLOT_W    = 3;
    localparam int SIZE_W    = 16;
    localparam int OFF_W     = 19;
    localparam int CNT_W     = 4;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTYFREE = 3'd4;

    // Command classes decided at the front
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_NULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] req;
        logic [OFF_W-1:0]  foff;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
        logic [OFF_W-1:0]  slot_offset;
        logic [CNT_W-1:0]  used_count;
    } t_result;

endpackage

`default_nettype wire

@@ design/spa_front.sv @@
`default_nettype none

module spa_front import spa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic              i_cmd,
    input  wire logic [SIZE_W-1:0] i_request_size,
    input  wire logic [OFF_W-1:0]  i_free_offset,
    input  wire logic              i_free_is_null,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output t_cmd                   o_cmd
);

    // two-entry command queue
    t_cmd       r_q [0:1];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push_ok, w_pop_ok;

    // classify the incoming item
    always_comb begin
        w_cmd.req  = i_request_size;
        w_cmd.foff = i_free_offset;
        if (!i_cmd)
            w_cmd.kind = K_ALLOC;
        else if (i_free_is_null)
            w_cmd.kind = K_NULL;
        else
            w_cmd.kind = K_FREE;
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_push_ok   = i_push && !o_full;
    assign w_pop_ok    = o_cmd_valid && i_cmd_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push_ok)
                r_wr <= ~r_wr;
            if (w_pop_ok)
                r_rd <= ~r_rd;
            if (w_push_ok && !w_pop_ok)
                r_count <= r_count + 2'd1;
            else if (w_pop_ok && !w_push_ok)
                r_count <= r_count - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok)
            r_q[r_wr] <= w_cmd;
    end

`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= 2'd2)
    `ASSERT_IMPLY(a_ptrs_full, i_clk, i_rst_n, r_count == 2'd2, r_wr == r_rd)

endmodule

`default_nettype wire

@@ design/spa_back.sv @@
`default_nettype none

module spa_back import spa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    input  wire logic                 i_cmd_valid,
    output logic                      o_cmd_ready,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_pop,
    output logic                      o_res_valid,
    output t_result                   o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [SIZE_W-1:0] r_size [0:REG_COUNT-1];
    logic [SLOTS-1:0]  r_busy, n_busy;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_state;
    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_k;
    logic [OFF_W-1:0]  r_acc;
    logic              r_out_valid;
    t_result           r_res, w_res;
    logic              w_done, w_last, w_commit;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;
    assign w_last      = (r_k == SLOT_W'(SLOTS - 1));
    assign w_commit    = (r_state == S_SCAN) && w_done && (!r_out_valid || i_pop);

    // decision for the slot under the scan pointer
    always_comb begin
        w_done  = 1'b0;
        n_busy  = r_busy;
        n_total = r_total;
        w_res.status      = ST_NOTFOUND;
        w_res.slot_index  = '0;
        w_res.slot_offset = '0;
        case (r_cmd.kind)
            K_ALLOC: begin
                if (r_total >= CNT_W'(SLOTS)) begin
                    w_done       = 1'b1;
                    w_res.status = ST_FULL;
                end else if (!r_busy[r_k] && r_size[r_k] >= r_cmd.req) begin
                    w_done            = 1'b1;
                    w_res.status      = ST_OK;
                    w_res.slot_index  = r_k;
                    w_res.slot_offset = r_acc;
                    n_busy[r_k]       = 1'b1;
                    n_total           = r_total + CNT_W'(1);
                end else if (w_last) begin
                    w_done       = 1'b1;
                    w_res.status = ST_NOFIT;
                end
            end
            K_FREE: begin
                if (r_acc == r_cmd.foff) begin
                    w_done            = 1'b1;
                    w_res.slot_index  = r_k;
                    w_res.slot_offset = r_acc;
                    if (r_busy[r_k]) begin
                        w_res.status = ST_OK;
                        n_busy[r_k]  = 1'b0;
                        if (r_total != '0)
                            n_total = r_total - CNT_W'(1);
                    end else begin
                        w_res.status = ST_EMPTYFREE;
                    end
                end else if (w_last) begin
                    w_done = 1'b1;
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_res.used_count = n_total;
    end

    // control state, pool state and slot sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
                r_size[i] <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(REG_COUNT))
                r_size[i_cfg_index[SLOT_W-1:0]] <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid)
                        r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        r_busy  <= n_busy;
                        r_total <= n_total;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_commit)
                r_out_valid <= 1'b1;
            else if (i_pop)
                r_out_valid <= 1'b0;
        end
    end

    // scan pointer, running offset and result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
            r_k   <= '0;
            r_acc <= '0;
        end else if (r_state == S_SCAN && !w_done) begin
            r_k   <= r_k + SLOT_W'(1);
            r_acc <= r_acc + OFF_W'(r_size[r_k]);
        end
        if (w_commit)
            r_res <= w_res;
    end

`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_total_matches, i_clk, i_rst_n, $countones(r_busy) == int'(r_total))
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n,
        r_out_valid && r_res.status == ST_FULL, r_res.used_count == CNT_W'(SLOTS))
    `ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n,
        r_out_valid && (r_res.status == ST_FULL || r_res.status == ST_NOFIT ||
        r_res.status == ST_NOTFOUND), r_res.slot_index == '0 && r_res.slot_offset == '0)

endmodule

`default_nettype wire

@@ design/slot_pool_allocator.sv @@
// First-fit allocator over a pool of eight slots laid out back to back; slot i
// starts at the sum of the configured sizes of slots 0..i-1. Items enter a
// two-entry command queue (push/full) and leave through a one-entry result
// register (empty/pop), so a new item is taken while a result waits. The back
// end scans one slot per cycle, adding up offsets as it goes, and stops at the
// first slot that decides the item; a full pool or a null free is decided at
// slot 0. A result is written only once the result register is free or popped.
// Slot size registers are written through the cfg port, index 0..7, which is
// always ready; indexes 8..15 are ignored. Write sizes only while idle.
`default_nettype none

module slot_pool_allocator import spa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_cmd,
    input  wire logic [SIZE_W-1:0]    i_request_size,
    input  wire logic [OFF_W-1:0]     i_free_offset,
    input  wire logic                 i_free_is_null,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [STAT_W-1:0]         o_status,
    output logic [SLOT_W-1:0]         o_slot_index,
    output logic [OFF_W-1:0]          o_slot_offset,
    output logic [CNT_W-1:0]          o_used_count,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data
);

    t_cmd    w_cmd;
    logic    w_cmd_valid, w_cmd_ready, w_res_valid;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    spa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_request_size (i_request_size),
        .i_free_offset  (i_free_offset),
        .i_free_is_null (i_free_is_null),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_ready    (w_cmd_ready),
        .o_cmd          (w_cmd)
    );

    spa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result ports
    assign empty         = !w_res_valid;
    assign o_status      = w_res.status;
    assign o_slot_index  = w_res.slot_index;
    assign o_slot_offset = w_res.slot_offset;
    assign o_used_count  = w_res.used_count;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import spa_pkg::*;

    // Command codes of the cmd field
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Slot size registers sit at consecutive indexes; indexes past the pool are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE_BASE = '0;

    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 16;
    localparam int QUIET_LIMIT     = 1000;

    // Mirror of the pool: predicts one result per item and checks the block's results
    class pool_scoreboard;
        logic [SIZE_W-1:0] slot_size [REG_COUNT];
        bit                slot_busy [REG_COUNT];
        logic [CNT_W-1:0]  busy_total;
        t_result           pending_results [$];
        int                mismatches;
        int                items_seen;
        int                writes_seen;
        int                status_seen [8];

        function new();
            for (int k = 0; k < REG_COUNT; k++) begin
                slot_size[k] = '0;
                slot_busy[k] = 1'b0;
            end
            for (int s = 0; s < 8; s++) status_seen[s] = 0;
            busy_total  = '0;
            mismatches  = 0;
            items_seen  = 0;
            writes_seen = 0;
        endfunction

        function void write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            writes_seen++;
            if (idx < REG_COUNT) slot_size[idx[SLOT_W-1:0]] = data;
        endfunction

        // Slot k starts right after the sizes of all slots below it
        function logic [OFF_W-1:0] offset_of(int k);
            logic [OFF_W+3:0] sum;
            sum = '0;
            for (int j = 0; j < k && j < REG_COUNT; j++) sum += slot_size[j];
            return sum[OFF_W-1:0];
        endfunction

        function void note_item(logic cmd, logic [SIZE_W-1:0] req,
                                logic [OFF_W-1:0] foff, logic is_null);
            t_result r;
            bit      found;
            r.status      = ST_NOTFOUND;
            r.slot_index  = '0;
            r.slot_offset = '0;
            found         = 1'b0;
            items_seen++;
            if (cmd == CMD_ALLOC) begin
                if (busy_total >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    r.status = ST_NOFIT;
                    // first fit: lowest empty slot large enough
                    for (int k = 0; k < SLOTS; k++) begin
                        if (!found && !slot_busy[k] && slot_size[k] >= req) begin
                            found         = 1'b1;
                            slot_busy[k]  = 1'b1;
                            busy_total    = busy_total + 1'b1;
                            r.status      = ST_OK;
                            r.slot_index  = k[SLOT_W-1:0];
                            r.slot_offset = offset_of(k);
                        end
                    end
                end
            end else if (!is_null) begin
                // shared offsets: only the lowest slot at that offset matches
                for (int k = 0; k < SLOTS; k++) begin
                    if (!found && offset_of(k) == foff) begin
                        found         = 1'b1;
                        r.slot_index  = k[SLOT_W-1:0];
                        r.slot_offset = foff;
                        if (slot_busy[k]) begin
                            slot_busy[k] = 1'b0;
                            if (busy_total > 0) busy_total = busy_total - 1'b1;
                            r.status = ST_OK;
                        end else begin
                            r.status = ST_EMPTYFREE;
                        end
                    end
                end
            end
            r.used_count = busy_total;
            pending_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.slot_index !== want.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.slot_offset !== want.slot_offset) begin
                $display("%0t: slot_offset expected %0d actual %0d",
                         $time, want.slot_offset, got.slot_offset);
                mismatches++;
            end
            if (got.used_count !== want.used_count) begin
                $display("%0t: used_count expected %0d actual %0d",
                         $time, want.used_count, got.used_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic                 i_cmd;
    logic [SIZE_W-1:0]    i_request_size;
    logic [OFF_W-1:0]     i_free_offset;
    logic                 i_free_is_null;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [OFF_W-1:0]     o_slot_offset;
    logic [CNT_W-1:0]     o_used_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;

    pool_scoreboard    sb;
    bit                idle_on;
    int                layouts_seen;
    logic [SIZE_W-1:0] layout [REG_COUNT];

    slot_pool_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_request_size (i_request_size),
        .i_free_offset  (i_free_offset),
        .i_free_is_null (i_free_is_null),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_slot_offset  (o_slot_offset),
        .o_used_count   (o_used_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random stalls, checked at the rising edge
    always @(negedge i_clk) begin
        pop <= i_rst_n && !(idle_on && $urandom_range(0, 99) < 14);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && pop && !empty) begin
            got.status      = o_status;
            got.slot_index  = o_slot_index;
            got.slot_offset = o_slot_offset;
            got.used_count  = o_used_count;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run after too many cycles with no handshake at all
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Called just after a falling edge; returns just after the falling edge past acceptance
    task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] req,
                             input logic [OFF_W-1:0] foff, input logic is_null);
        while (idle_on && $urandom_range(0, 99) < 14) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push           = 1'b1;
        i_cmd          = cmd;
        i_request_size = req;
        i_free_offset  = foff;
        i_free_is_null = is_null;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_item(cmd, req, foff, is_null);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_size(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Block is idle once every result is back and the back end has had time to settle
    task automatic wait_idle();
        push = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_layout(input bit with_ignored);
        wait_idle();
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(REG_SLOT_SIZE_BASE + k[CFG_IDX_W-1:0], layout[k]);
        if (with_ignored)
            write_reg(REG_SLOT_SIZE_BASE + REG_COUNT[CFG_IDX_W-1:0]
                      + CFG_IDX_W'($urandom_range(0, 7)),
                      SIZE_W'($urandom_range(0, 65535)));
        layouts_seen++;
    endtask

    // mode 0: small sizes, 1: full range, 2: extremes only
    function automatic logic [SIZE_W-1:0] pick_size(int mode);
        case (mode)
            0: begin
                return (($urandom_range(0, 4) == 0) ? 16'd0
                                                    : SIZE_W'($urandom_range(1, 40)));
            end
            1: begin
                return SIZE_W'($urandom_range(0, 65535));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return 16'd65534;
                    default: return 16'd65535;
                endcase
            end
        endcase
    endfunction

    // Mostly allocate/free pairs on live slots, with some stray and null frees
    task automatic random_item();
        logic              cmd;
        logic [SIZE_W-1:0] req;
        logic [OFF_W-1:0]  foff;
        logic              is_null;
        int                k;
        int                pick;
        cmd     = $urandom_range(0, 1) ? CMD_FREE : CMD_ALLOC;
        req     = SIZE_W'($urandom_range(0, 65535));
        foff    = OFF_W'($urandom_range(0, 524287));
        is_null = ($urandom_range(0, 11) == 0);
        k       = $urandom_range(0, REG_COUNT - 1);
        if (cmd == CMD_ALLOC) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                req = '0;
            else if (pick == 1)
                req = 16'hFFFF;
            else if (pick > 3)
                req = SIZE_W'(sb.slot_size[k] + $urandom_range(0, 2) - 1);
        end else begin
            for (int t = 0; t < 3 && !sb.slot_busy[k]; t++)
                k = $urandom_range(0, REG_COUNT - 1);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                foff = sb.offset_of(k);
            else if (pick == 7)
                foff = sb.offset_of(k) + 1'b1;
        end
        send_item(cmd, req, foff, is_null);
    endtask

    initial begin
        sb             = new();
        idle_on        = 1'b1;
        layouts_seen   = 1;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_cmd          = CMD_ALLOC;
        i_request_size = '0;
        i_free_offset  = '0;
        i_free_is_null = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset sizes: every slot has size zero, so all share offset 0
        send_item(CMD_ALLOC, 16'd0, '0, 1'b0);
        send_item(CMD_ALLOC, 16'd1, '0, 1'b0);
        send_item(CMD_FREE, '0, 19'd0, 1'b0);
        send_item(CMD_FREE, '0, 19'd0, 1'b0);
        send_item(CMD_FREE, '0, 19'd0, 1'b1);

        // Mixed sizes with two zero-size slots sharing offsets
        layout = '{16'd16, 16'd32, 16'd0, 16'd64, 16'd8, 16'd128, 16'd0, 16'd256};
        program_layout(1'b0);
        repeat (SLOTS) send_item(CMD_ALLOC, 16'd0, '0, 1'b0);
        send_item(CMD_ALLOC, 16'd0, '0, 1'b0);
        send_item(CMD_FREE, '0, 19'd48, 1'b0);
        send_item(CMD_FREE, '0, 19'd48, 1'b0);
        send_item(CMD_FREE, '0, 19'd7, 1'b0);
        send_item(CMD_FREE, '0, 19'd16, 1'b1);

        // Largest sizes: offsets reach the top bits
        for (int k = 0; k < REG_COUNT; k++) layout[k] = 16'hFFFF;
        program_layout(1'b1);
        send_item(CMD_ALLOC, 16'hFFFF, '0, 1'b0);
        send_item(CMD_FREE, '0, 19'd458745, 1'b0);
        send_item(CMD_ALLOC, 16'hFFFE, '0, 1'b0);
        send_item(CMD_FREE, '0, 19'h7FFFF, 1'b0);

        // Random layouts; one phase runs with no idling on either side
        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int k = 0; k < REG_COUNT; k++) layout[k] = pick_size(p % 3);
            program_layout(p == 1 || p == 4);
            idle_on = (p != 2);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        wait_idle();
        $display("Covered %0d items and %0d register writes over %0d slot layouts.",
                 sb.items_seen, sb.writes_seen, layouts_seen);
        $display("Results: %0d ok, %0d full, %0d no fit, %0d not found or null, %0d empty free.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_NOFIT],
                 sb.status_seen[ST_NOTFOUND], sb.status_seen[ST_EMPTYFREE]);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
